/* rtl/wpoc_pkg.sv */
// Package for the wildcard pattern occurrence counter.
// Holds sizes, register codes, the cell control type and the per-cell pattern select.
// No dependencies.
package wpoc_pkg;

  localparam int MAX_PATTERN_LEN = 8;
  localparam int LEN_W = 4;
  localparam int POS_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int SYM_W = 8;
  localparam int CNT_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [SYM_W-1:0] WILDCARD_CHAR = 8'h2E;
  localparam logic [LEN_W-1:0] MAX_LEN_VAL = LEN_W'(MAX_PATTERN_LEN);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_CHARS  = 3'd0,
    REG_WILDCARD_MASK  = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_THRESHOLD      = 3'd3,
    REG_THRESHOLD_MODE = 3'd4
  } wpoc_reg_t;

  // What one window cell compares against.
  typedef struct packed {
    logic             active;
    logic             wild;
    logic [SYM_W-1:0] ref_byte;
  } wpoc_cell_ctl_t;

  // One window test handed to the counter.
  typedef struct packed {
    logic fire;
    logic hit;
    logic last;
  } wpoc_step_t;

  // Cell i holds the character i places before the newest; it meets
  // pattern position eff_len-1-i.
  function automatic wpoc_cell_ctl_t cell_ctl(
    input int                                 idx,
    input logic [SYM_W*MAX_PATTERN_LEN-1:0]   chars,
    input logic [MAX_PATTERN_LEN-1:0]         mask,
    input logic [LEN_W-1:0]                   eff_len
  );
    wpoc_cell_ctl_t   ctl;
    logic [LEN_W-1:0] span;
    logic [POS_W-1:0] pos;
    span = eff_len - LEN_W'(idx) - LEN_W'(1);
    pos = span[POS_W-1:0];
    ctl.active = (eff_len > LEN_W'(idx));
    ctl.ref_byte = chars[SYM_W*pos +: SYM_W];
    ctl.wild = mask[pos] || (ctl.ref_byte == WILDCARD_CHAR);
    return ctl;
  endfunction

endpackage

/* rtl/wpoc_cell.sv */
// One window cell: holds a character, passes it on, compares it with its pattern byte.
// Depends on wpoc_pkg.
module wpoc_cell (
  input  logic                   clk,
  input  logic                   shift,
  input  logic [7:0]             char_in,
  input  wpoc_pkg::wpoc_cell_ctl_t ctl,
  output logic [7:0]             char_out,
  output logic                   hit
);
  import wpoc_pkg::*;

  logic [SYM_W-1:0] char_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      char_q <= char_in;
    end
  end

  assign char_out = char_q;
  // An inactive cell lies outside the pattern and never blocks a match.
  assign hit = !ctl.active || ctl.wild || (ctl.ref_byte == char_q);

endmodule

/* rtl/wpoc_counter.sv */
// Running match count, threshold cap and the result output register.
// Depends on wpoc_pkg.
module wpoc_counter (
  input  logic                 clk,
  input  logic                 rst,
  input  wpoc_pkg::wpoc_step_t step,
  input  logic [31:0]          threshold,
  input  logic                 threshold_mode,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          occurrence_count,
  output logic                 threshold_reached
);
  import wpoc_pkg::*;

  logic [CNT_W-1:0] match_count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cap;
  logic             inc;

  assign cap = (threshold == '0) ? CNT_W'(1) : threshold;
  assign inc = step.hit && (threshold_mode ? (match_count < cap) : (match_count != '1));
  assign count_next = match_count + CNT_W'(inc);
  // A last-of-set test needs the output slot.
  assign take = !step.last || !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step.fire && step.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (step.fire) begin
        if (step.last) begin
          match_count <= '0;
        end else begin
          match_count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire && step.last) begin
      occurrence_count <= count_next;
      threshold_reached <= (count_next >= threshold);
    end
  end

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    step.fire && step.last |=> out_valid && (match_count == '0))
    else $error("result not loaded or count not cleared at end of set");
  a_reached_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> threshold_reached == (occurrence_count >= threshold))
    else $error("threshold flag disagrees with count");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(step.fire && step.last))
    else $error("waiting result overwritten");
`endif

endmodule

/* rtl/wildcard_pattern_occurrence_counter.sv */
// Top level of the wildcard pattern occurrence counter.
// Depends on wpoc_pkg, wpoc_cell and wpoc_counter.
// Characters enter a row of window cells, newest in cell 0; the counter keeps the tally.
//
// The block takes one character per clock while in_stall is low and keeps
// doing so indefinitely. Each accepted transaction shifts the row of eight
// window cells by one; in the following cycle every cell compares its
// character with the pattern byte that lines up with it, and the per-cell
// hits are ANDed and handed to the match counter, so the parallel compare
// and count update set the rate. A result transaction is loaded into the
// output register when the window stage holding the character marked
// end_of_set passes it on to the counter. The output register and the window
// stage together act as a skid: input stalls only when an end-of-set character
// sits in the window stage while the previous result is still held by a
// stalled output. Configuration writes are always ready and must only be
// issued while the block is idle; unused register indices are ignored.
module wildcard_pattern_occurrence_counter (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wpoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wpoc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // character stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         symbol,
  input  logic                               end_of_sequence,
  input  logic                               end_of_set,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        occurrence_count,
  output logic                               threshold_reached
);
  import wpoc_pkg::*;

  // Configuration registers.
  logic [SYM_W*MAX_PATTERN_LEN-1:0] pattern_chars;
  logic [MAX_PATTERN_LEN-1:0]       wildcard_mask;
  logic [LEN_W-1:0]                 pattern_length;
  logic [CNT_W-1:0]                 threshold;
  logic                             threshold_mode;

  // Sequence position and the window stage control.
  logic [LEN_W-1:0] seq_cnt;
  logic [LEN_W-1:0] seq_cnt_inc;
  logic [LEN_W-1:0] s1_cnt;
  logic             s1_valid;
  logic             s1_last;

  logic             accept;
  logic             take;
  logic             advance;
  logic [LEN_W-1:0] eff_len;
  wpoc_step_t       step;

  logic [SYM_W-1:0]           chain [MAX_PATTERN_LEN+1];
  logic [MAX_PATTERN_LEN-1:0] cell_hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_chars <= '0;
      wildcard_mask <= '0;
      pattern_length <= LEN_W'(1);
      threshold <= CNT_W'(1);
      threshold_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_CHARS:  pattern_chars <= cfg_data[SYM_W*MAX_PATTERN_LEN-1:0];
        REG_WILDCARD_MASK:  wildcard_mask <= cfg_data[MAX_PATTERN_LEN-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_THRESHOLD:      threshold <= cfg_data[CNT_W-1:0];
        REG_THRESHOLD_MODE: threshold_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp over-long patterns to the window depth.
  assign eff_len = (pattern_length > MAX_LEN_VAL) ? MAX_LEN_VAL : pattern_length;

  // Hold the window stage while its end-of-set test cannot reach the output.
  assign advance  = s1_valid && take;
  assign in_stall = s1_valid && !take;
  assign accept   = in_valid && !in_stall;

  assign seq_cnt_inc = (seq_cnt < MAX_LEN_VAL) ? seq_cnt + LEN_W'(1) : seq_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cnt <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        // Drop back to the start of a sequence at either boundary.
        seq_cnt <= (end_of_sequence || end_of_set) ? '0 : seq_cnt_inc;
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cnt <= seq_cnt_inc;
      s1_last <= end_of_set;
    end
  end

  // Window cells: cell 0 takes the new symbol, each cell feeds the next.
  assign chain[0] = symbol;

  for (genvar i = 0; i < MAX_PATTERN_LEN; i++) begin : g_cell
    wpoc_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .char_in  (chain[i]),
      .ctl      (cell_ctl(i, pattern_chars, wildcard_mask, eff_len)),
      .char_out (chain[i+1]),
      .hit      (cell_hit[i])
    );
  end

  // A window counts only once the sequence holds a full pattern's worth.
  assign step.fire = advance;
  assign step.last = s1_last;
  assign step.hit  = (eff_len != '0) && (s1_cnt >= eff_len) && (&cell_hit);

  wpoc_counter u_counter (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .threshold         (threshold),
    .threshold_mode    (threshold_mode),
    .take              (take),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .occurrence_count  (occurrence_count),
    .threshold_reached (threshold_reached)
  );

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_last && out_valid)
    else $error("input stalled without a blocked end of set");
  a_seq_bound: assert property (@(posedge clk) disable iff (rst)
    seq_cnt <= MAX_LEN_VAL)
    else $error("sequence position beyond window depth");
  a_seq_restart: assert property (@(posedge clk) disable iff (rst)
    accept && (end_of_sequence || end_of_set) |=> seq_cnt == '0)
    else $error("sequence position not cleared at boundary");
`endif

endmodule
